[hdl/ksdp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ksdp_pkg;

  localparam int unsigned ROW_ENTRIES_DEF = 1024;
  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned CAP_WIDTH       = 10;
  localparam int unsigned WEIGHT_WIDTH    = 16;
  localparam int unsigned ITEM_VAL_WIDTH  = 16;
  localparam int unsigned BEST_WIDTH      = 32;

  localparam logic [CAP_WIDTH-1:0] CAP_RESET = 10'd1023;

  typedef struct packed {
    logic [WEIGHT_WIDTH-1:0]   item_weight;
    logic [ITEM_VAL_WIDTH-1:0] item_value;
    logic                      last_item;
  } in_word_t;

  typedef struct packed {
    logic [BEST_WIDTH-1:0] best_value;
    logic                  saturated;
  } out_word_t;

endpackage

`default_nettype wire

[hdl/ksdp_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module ksdp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_a_addr_i,
  output logic      [WIDTH-1:0]         rd_a_data_o,
  input  wire logic [$clog2(DEPTH)-1:0] rd_b_addr_i,
  output logic      [WIDTH-1:0]         rd_b_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_a_data_o <= mem_q[rd_a_addr_i];
    rd_b_data_o <= mem_q[rd_b_addr_i];
  end

endmodule

`default_nettype wire

[hdl/knapsack_01_dp_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// An item of weight w <= cap sweeps the row from cap down to w, one entry per cycle
// (two reads, one read-modify-write of the row RAM), then passes through a drain state.
// A heavier item is accepted without a sweep. On a last item the row entry at cap is read
// (after the drain, or at once for a heavier item), then the result word is loaded into
// the output register (held while it is full); a clearing pass of ROW_ENTRIES entries
// then zeroes the row. After reset the same clearing pass runs; capacity resets to 1023.
// Items are taken one at a time: no new item is accepted until the block is back in idle.
module knapsack_01_dp_top #(
  parameter int unsigned ROW_ENTRIES = ksdp_pkg::ROW_ENTRIES_DEF,
  parameter int unsigned VALUE_WIDTH = ksdp_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire ksdp_pkg::in_word_t                 in_word_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output ksdp_pkg::out_word_t                     out_word_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [ksdp_pkg::CAP_WIDTH-1:0]     cfg_data_i
);

  import ksdp_pkg::*;

  localparam int unsigned AW = $clog2(ROW_ENTRIES);
  localparam int unsigned CW = (AW > CAP_WIDTH) ? AW : CAP_WIDTH;
  localparam int unsigned SW = VALUE_WIDTH + 1;
  localparam logic [AW-1:0] LAST_ENTRY = AW'(ROW_ENTRIES - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_RD_RES,
    ST_RES,
    ST_CLEAR
  } state_e;

  state_e                    state_q, state_d;
  logic [CAP_WIDTH-1:0]      cap_q, cap_d;
  logic [AW-1:0]             c_q, c_d;
  logic [AW-1:0]             w_q, w_d;
  logic [ITEM_VAL_WIDTH-1:0] v_q, v_d;
  logic                      last_q, last_d;
  logic [AW-1:0]             wa_q, wa_d;
  logic                      rd_vld_q, rd_vld_d;
  logic                      clip_q, clip_d;
  logic [AW-1:0]             clr_q, clr_d;
  logic                      out_valid_q, out_valid_d;
  out_word_t                 out_word_q, out_word_d;

  logic [CW-1:0]           cap_ext;
  logic [AW-1:0]           cap_eff;
  logic                    fits;
  logic                    in_acc;
  logic                    out_free;
  logic [AW-1:0]           rd_a_addr, rd_b_addr;
  logic [VALUE_WIDTH-1:0]  rd_a_data, rd_b_data;
  logic [SW-1:0]           sum;
  logic [VALUE_WIDTH-1:0]  cand;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic [VALUE_WIDTH-1:0]  wr_data;
  logic [BEST_WIDTH-1:0]   res_best;
  logic                    res_wide;

  assign cap_ext = CW'(cap_q);
  assign cap_eff = (cap_ext < CW'(ROW_ENTRIES - 1)) ? AW'(cap_ext) : LAST_ENTRY;
  assign fits    = (in_word_i.item_weight <= WEIGHT_WIDTH'(cap_eff));

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  assign rd_a_addr = (state_q == ST_RD_RES || state_q == ST_RES) ? cap_eff : c_q;
  assign rd_b_addr = c_q - w_q;

  assign sum  = {1'b0, rd_b_data} + SW'(v_q);
  assign cand = sum[VALUE_WIDTH] ? {VALUE_WIDTH{1'b1}} : sum[VALUE_WIDTH-1:0];

  always_comb begin
    if (state_q == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_q;
      wr_data = '0;
    end else begin
      wr_en   = rd_vld_q && (cand > rd_a_data);
      wr_addr = wa_q;
      wr_data = cand;
    end
  end

  generate
    if (VALUE_WIDTH > BEST_WIDTH) begin : g_wide
      assign res_wide = |rd_a_data[VALUE_WIDTH-1:BEST_WIDTH];
      assign res_best = res_wide ? {BEST_WIDTH{1'b1}} : rd_a_data[BEST_WIDTH-1:0];
    end else begin : g_narrow
      assign res_wide = 1'b0;
      assign res_best = BEST_WIDTH'(rd_a_data);
    end
  endgenerate

  ksdp_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (ROW_ENTRIES)
  ) u_row (
    .clk_i       (clk_i),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .rd_a_addr_i (rd_a_addr),
    .rd_a_data_o (rd_a_data),
    .rd_b_addr_i (rd_b_addr),
    .rd_b_data_o (rd_b_data)
  );

  always_comb begin
    state_d     = state_q;
    cap_d       = cap_q;
    c_d         = c_q;
    w_d         = w_q;
    v_d         = v_q;
    last_d      = last_q;
    wa_d        = wa_q;
    rd_vld_d    = 1'b0;
    clip_d      = clip_q || (rd_vld_q && sum[VALUE_WIDTH]);
    clr_d       = clr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_word_d  = out_word_q;

    if (cfg_valid_i && cfg_ready_o) begin
      cap_d = cfg_data_i;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          c_d    = cap_eff;
          w_d    = AW'(in_word_i.item_weight);
          v_d    = in_word_i.item_value;
          last_d = in_word_i.last_item;
          if (fits) begin
            state_d = ST_SWEEP;
          end else if (in_word_i.last_item) begin
            state_d = ST_RD_RES;
          end
        end
      end
      ST_SWEEP: begin
        rd_vld_d = 1'b1;
        wa_d     = c_q;
        if (c_q == w_q) begin
          state_d = ST_DRAIN;
        end else begin
          c_d = c_q - 1'b1;
        end
      end
      ST_DRAIN: begin
        state_d = last_q ? ST_RD_RES : ST_IDLE;
      end
      ST_RD_RES: begin
        state_d = ST_RES;
      end
      ST_RES: begin
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_word_d.best_value = res_best;
          out_word_d.saturated  = clip_q || res_wide;
          clip_d                = 1'b0;
          clr_d                 = '0;
          state_d               = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        if (clr_q == LAST_ENTRY) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cap_q       <= CAP_RESET;
      rd_vld_q    <= 1'b0;
      clip_q      <= 1'b0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cap_q       <= cap_d;
      rd_vld_q    <= rd_vld_d;
      clip_q      <= clip_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q        <= c_d;
    w_q        <= w_d;
    v_q        <= v_d;
    last_q     <= last_d;
    wa_q       <= wa_d;
    out_word_q <= out_word_d;
  end

  // downward sweep: a pending write never lands on an entry still to be read
  a_write_above_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_vld_q && state_q == ST_SWEEP) |-> (wa_q > c_q))
    else $error("row write at or below current read address");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !rd_vld_q)
    else $error("new word accepted with row write pending");

  a_clear_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> (!clip_q && !rd_vld_q))
    else $error("clip flag or sweep active during clear");

  a_result_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RES && !out_free) |=> (state_q == ST_RES))
    else $error("result dropped while output busy");

endmodule

`default_nettype wire
